>>> rtl/flst_pkg.sv
`default_nettype none

package flst_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 16;
   localparam int ADDR_W              = 64;
   localparam int STRIKES_W           = 4;
   localparam int ENTRIES_W           = 5;
   localparam int REQ_DATA_W          = 128;
   localparam int REQ_USER_W          = 3;
   localparam int RSP_DATA_W          = 16;
   localparam logic [STRIKES_W-1:0] LIMIT_RESET = 4'd3;

   typedef enum logic [1:0] {
      KIND_STRIKE = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_HOLD      = 2'd0,
      OP_SHIFT     = 2'd1,
      OP_SWAP_EVEN = 2'd2,
      OP_SWAP_ODD  = 2'd3
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_SORT = 2'd2,
      ST_RESP = 2'd3
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic                 family;
      logic [ADDR_W-1:0]    addr_high;
      logic [ADDR_W-1:0]    addr_low;
      logic [STRIKES_W-1:0] strikes;
   } flst_entry_type;

   typedef struct packed {
      cell_op_type    op;
      flst_entry_type tail;
   } flst_cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/flst_cell.sv
`default_nettype none

module flst_cell #(
   parameter int CELL_INDEX  = 0,
   parameter int TABLE_DEPTH = flst_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  flst_pkg::cell_op_type   op,
   input  flst_pkg::flst_entry_type left_entry,
   input  flst_pkg::flst_entry_type right_entry,
   output flst_pkg::flst_entry_type entry
);
   import flst_pkg::*;

   localparam logic IS_ODD    = (CELL_INDEX % 2) == 1;
   localparam logic HAS_LEFT  = CELL_INDEX > 0;
   localparam logic HAS_RIGHT = CELL_INDEX < TABLE_DEPTH - 1;

   flst_entry_type entry_ff;
   flst_entry_type entry_in;
   logic           phase;
   logic           left_member;
   logic           right_member;

   assign phase        = (op == OP_SWAP_ODD);
   assign left_member  = HAS_RIGHT && (IS_ODD == phase);
   assign right_member = HAS_LEFT && (IS_ODD != phase);

   always_comb begin
      entry_in = entry_ff;
      case (op)
         OP_HOLD: begin
            entry_in = entry_ff;
         end
         OP_SHIFT: begin
            entry_in = right_entry;
         end
         OP_SWAP_EVEN, OP_SWAP_ODD: begin
            // odd-even exchange: a hole sinks towards the tail, valid order kept
            if (left_member && !entry_ff.valid && right_entry.valid) begin
               entry_in = right_entry;
            end else if (right_member && !left_entry.valid && entry_ff.valid) begin
               entry_in = left_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid   <= 1'b0;
         entry_ff.strikes <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

>>> rtl/flst_ctrl.sv
`default_nettype none

module flst_ctrl #(
   parameter int TABLE_DEPTH = flst_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire  [flst_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire  [flst_pkg::REQ_USER_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic [flst_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire                                    csr_wr_en,
   input  wire  [flst_pkg::STRIKES_W-1:0]         csr_wr_data,
   input  flst_pkg::flst_entry_type               head_entry,
   output flst_pkg::flst_cell_ctl_type            cell_ctl
);
   import flst_pkg::*;

   localparam int CW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int UW  = $clog2(TABLE_DEPTH + 1);
   localparam int UXW = UW + ENTRIES_W;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   kind_type                kind_ff, kind_in;
   logic                    family_ff, family_in;
   logic [ADDR_W-1:0]       addr_high_ff, addr_high_in;
   logic [ADDR_W-1:0]       addr_low_ff, addr_low_in;
   logic                    done_ff, done_in;
   logic [STRIKES_W-1:0]    res_strikes_ff, res_strikes_in;
   logic                    res_blocked_ff, res_blocked_in;
   logic [UW-1:0]           used_ff, used_in;
   logic [UW-1:0]           surv_ff, surv_in;
   logic [STRIKES_W-1:0]    limit_ff, limit_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    last;
   logic                    accept;
   logic                    rsp_free;
   logic                    match;
   logic                    drop;
   logic [STRIKES_W-1:0]    dec;
   logic [UXW-1:0]          used_wide;
   flst_entry_type          tail;

   assign last      = (cnt_ff == CW'(TABLE_DEPTH - 1));
   assign accept    = req_tvalid && req_tready;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign match     = head_entry.valid && (head_entry.family == family_ff) &&
                      (head_entry.addr_high == addr_high_ff) &&
                      (head_entry.addr_low == addr_low_ff);
   assign drop      = (kind_ff == KIND_STRIKE) && !done_ff;
   assign dec       = head_entry.strikes - STRIKES_W'(1);
   assign used_wide = UXW'(used_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last) begin
               state_in = (kind_ff == KIND_TICK) ? ST_SORT : ST_RESP;
            end
         end
         ST_SORT: begin
            if (last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready    = 1'b0;
      cell_ctl.op   = OP_HOLD;
      cell_ctl.tail = tail;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
            cell_ctl.op = OP_SHIFT;
         end
         ST_SORT: begin
            cell_ctl.op = cnt_ff[0] ? OP_SWAP_ODD : OP_SWAP_EVEN;
         end
         ST_RESP: begin
            cell_ctl.op = OP_HOLD;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // head of the ring: inspect and rewrite the entry going round to the tail
   always_comb begin
      cnt_in         = cnt_ff;
      kind_in        = kind_ff;
      family_in      = family_ff;
      addr_high_in   = addr_high_ff;
      addr_low_in    = addr_low_ff;
      done_in        = done_ff;
      res_strikes_in = res_strikes_ff;
      res_blocked_in = res_blocked_ff;
      used_in        = used_ff;
      surv_in        = surv_ff;
      limit_in       = limit_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      tail           = head_entry;

      if (state_ff != ST_SCAN) begin
         tail       = head_entry;
         tail.valid = 1'b0;
      end

      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      if (accept) begin
         kind_in        = kind_type'(req_tuser[1:0]);
         family_in      = req_tuser[2];
         addr_high_in   = req_tuser[2] ? req_tdata[63:0] : '0;
         addr_low_in    = req_tuser[2] ? req_tdata[127:64] : {32'd0, req_tdata[95:64]};
         done_in        = 1'b0;
         res_strikes_in = '0;
         res_blocked_in = 1'b0;
         surv_in        = '0;
         cnt_in         = '0;
      end

      if (state_ff == ST_SCAN || state_ff == ST_SORT) begin
         cnt_in = last ? '0 : cnt_ff + CW'(1);
      end

      if (state_ff == ST_SCAN) begin
         case (kind_ff)
            KIND_STRIKE: begin
               if (!done_ff) begin
                  if (match && (head_entry.strikes < limit_ff)) begin
                     tail.strikes   = head_entry.strikes + STRIKES_W'(1);
                     done_in        = 1'b1;
                     res_strikes_in = head_entry.strikes + STRIKES_W'(1);
                  end else if (!head_entry.valid) begin
                     tail.valid     = 1'b1;
                     tail.family    = family_ff;
                     tail.addr_high = addr_high_ff;
                     tail.addr_low  = addr_low_ff;
                     tail.strikes   = STRIKES_W'(1);
                     done_in        = 1'b1;
                     res_strikes_in = STRIKES_W'(1);
                     used_in        = used_ff + UW'(1);
                  end
               end
            end
            KIND_QUERY: begin
               if (!done_ff && match) begin
                  done_in        = 1'b1;
                  res_strikes_in = head_entry.strikes;
                  res_blocked_in = head_entry.strikes >= limit_ff;
               end
            end
            KIND_TICK: begin
               if (head_entry.valid) begin
                  tail.strikes = dec;
                  if (dec == '0) begin
                     tail.valid = 1'b0;
                  end else begin
                     surv_in = surv_ff + UW'(1);
                  end
               end
            end
            default: begin
               tail = head_entry;
            end
         endcase
      end

      if (state_ff == ST_SORT && last) begin
         used_in = surv_ff;
      end

      if (state_ff == ST_RESP && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, used_wide[ENTRIES_W-1:0], drop, res_strikes_ff,
                         res_blocked_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         used_ff      <= '0;
         surv_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         used_ff      <= used_in;
         surv_ff      <= surv_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      family_ff      <= family_in;
      addr_high_ff   <= addr_high_in;
      addr_low_ff    <= addr_low_in;
      res_strikes_ff <= res_strikes_in;
      res_blocked_ff <= res_blocked_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_head_consistent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (head_entry.valid == (used_ff != '0)))
      else $error("head cell validity disagrees with fill count");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted beat did not start a scan");

   a_sort_tick_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> (kind_ff == KIND_TICK))
      else $error("compaction outside a decay tick");

endmodule

`default_nettype wire

>>> rtl/failed_login_strike_table.sv
`default_nettype none

// Failed-login strike table. Entries (address family, 128-bit address, 4-bit strike count)
// sit oldest first in a row of TABLE_DEPTH cells. Every request beat rotates the whole
// row once past a single compare unit at the head before the result of a strike, a query
// or an unknown kind is registered; a decay tick then also runs TABLE_DEPTH odd-even
// exchange steps to close the holes left by expired entries. One request is in flight
// at a time; a new beat is taken while the previous result still waits on the rsp side.
// A strike that finds no free cell is dropped and flagged. csr_wr_data sets the strike
// limit (reset 3) and must only be written while the table is idle. IPv4 requests
// ignore address_high and the upper half of address_low.
module failed_login_strike_table #(
   parameter int TABLE_DEPTH = flst_pkg::TABLE_DEPTH_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [flst_pkg::REQ_DATA_W-1:0]  req_tdata,   // address_high, address_low
   input  wire  [flst_pkg::REQ_USER_W-1:0]  req_tuser,   // kind, is_ipv6
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [flst_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // blocked, matched_strikes,
                                                         // table_full_drop, entries_used
   input  wire                              csr_wr_en,
   input  wire  [flst_pkg::STRIKES_W-1:0]   csr_wr_data
);
   import flst_pkg::*;

   flst_entry_type    entries [TABLE_DEPTH];
   flst_cell_ctl_type cell_ctl;

   flst_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .head_entry (entries[0]),
      .cell_ctl   (cell_ctl)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      flst_entry_type left_entry;
      flst_entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = '0;
      end else begin : g_inner_left
         assign left_entry = entries[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right_entry = cell_ctl.tail;
      end else begin : g_inner_right
         assign right_entry = entries[i+1];
      end

      flst_cell #(
         .CELL_INDEX (i),
         .TABLE_DEPTH(TABLE_DEPTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .op         (cell_ctl.op),
         .left_entry (left_entry),
         .right_entry(right_entry),
         .entry      (entries[i])
      );
   end

endmodule

`default_nettype wire

>>> tb/sv/failed_login_strike_table_test.sv
`default_nettype none

module failed_login_strike_table_test;
   import flst_pkg::*;

   localparam int DEPTH     = TABLE_DEPTH_DEFAULT;
   localparam int POOL_SIZE = 12;

   typedef struct packed {
      logic [ENTRIES_W-1:0] used;
      logic                 drop;
      logic [STRIKES_W-1:0] strikes;
      logic                 blocked;
   } verdict_type;

   class strike_ledger;
      logic [STRIKES_W-1:0] limit;
      bit                   row_valid [DEPTH];
      bit                   row_v6    [DEPTH];
      logic [ADDR_W-1:0]    row_hi    [DEPTH];
      logic [ADDR_W-1:0]    row_lo    [DEPTH];
      logic [STRIKES_W-1:0] row_count [DEPTH];
      verdict_type          awaited[$];
      int                   mismatches;

      function new();
         limit = LIMIT_RESET;
         mismatches = 0;
         for (int i = 0; i < DEPTH; i++) begin
            row_valid[i] = 0;
            row_v6[i]    = 0;
            row_hi[i]    = '0;
            row_lo[i]    = '0;
            row_count[i] = '0;
         end
      endfunction

      function int unsigned rows_in_use();
         int unsigned n;
         n = 0;
         for (int i = 0; i < DEPTH; i++)
            if (row_valid[i]) n++;
         return n;
      endfunction

      function bit same_peer(int i, bit v6, logic [ADDR_W-1:0] hi, logic [ADDR_W-1:0] lo);
         return row_valid[i] && row_v6[i] == v6 && row_hi[i] == hi && row_lo[i] == lo;
      endfunction

      function void note_request(kind_type kind, bit v6, logic [ADDR_W-1:0] hi,
                                 logic [ADDR_W-1:0] lo);
         verdict_type          v;
         bit                   done;
         int unsigned          j;
         logic [STRIKES_W-1:0] c;
         v = '0;
         if (!v6) begin
            hi = '0;
            lo[63:32] = '0;
         end
         case (kind)
            KIND_STRIKE: begin
               done = 0;
               for (int i = 0; i < DEPTH && !done; i++) begin
                  if (same_peer(i, v6, hi, lo) && row_count[i] < limit) begin
                     row_count[i] = row_count[i] + 1'b1;
                     v.strikes = row_count[i];
                     done = 1;
                  end
               end
               if (!done) begin
                  j = rows_in_use();
                  if (j < DEPTH) begin
                     row_valid[j] = 1;
                     row_v6[j]    = v6;
                     row_hi[j]    = hi;
                     row_lo[j]    = lo;
                     row_count[j] = 1;
                     v.strikes    = 1;
                  end else begin
                     v.drop = 1;
                  end
               end
            end
            KIND_QUERY: begin
               done = 0;
               for (int i = 0; i < DEPTH && !done; i++) begin
                  if (same_peer(i, v6, hi, lo)) begin
                     v.strikes = row_count[i];
                     v.blocked = row_count[i] >= limit;
                     done = 1;
                  end
               end
            end
            KIND_TICK: begin
               j = 0;
               for (int i = 0; i < DEPTH; i++) begin
                  if (row_valid[i]) begin
                     c = (row_count[i] != 0) ? row_count[i] - 1'b1 : '0;
                     if (c != 0) begin
                        row_valid[j] = 1;
                        row_v6[j]    = row_v6[i];
                        row_hi[j]    = row_hi[i];
                        row_lo[j]    = row_lo[i];
                        row_count[j] = c;
                        j++;
                     end
                  end
               end
               for (int i = j; i < DEPTH; i++) begin
                  row_valid[i] = 0;
                  row_count[i] = '0;
               end
            end
            default: ;
         endcase
         v.used = ENTRIES_W'(rows_in_use());
         awaited.push_back(v);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] data);
         verdict_type got, want;
         got = data[10:0];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat %h", data);
            return;
         end
         want = awaited.pop_front();
         if (got.blocked !== want.blocked || got.strikes !== want.strikes ||
             got.drop !== want.drop || got.used !== want.used) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: blocked %b/%b strikes %0d/%0d drop %b/%b used %0d/%0d",
                        want.blocked, got.blocked, want.strikes, got.strikes,
                        want.drop, got.drop, want.used, got.used);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic [REQ_USER_W-1:0]  req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en;
   logic [STRIKES_W-1:0]   csr_wr_data;

   strike_ledger           ledger;
   bit                     gaps_on;
   int                     rsp_stall;
   bit                     pool_v6 [POOL_SIZE];
   logic [ADDR_W-1:0]      pool_hi [POOL_SIZE];
   logic [ADDR_W-1:0]      pool_lo [POOL_SIZE];

   failed_login_strike_table uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side stalls in bursts
   initial begin
      rsp_tready = 0;
      rsp_stall  = 0;
      forever begin
         @(negedge clock);
         if (rsp_stall > 0)
            rsp_stall--;
         else if (gaps_on && $urandom_range(0, 7) == 0)
            rsp_stall = $urandom_range(1, 9);
         rsp_tready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         ledger.check_response(rsp_tdata);
   end

   task automatic send_request(input kind_type kind, input bit v6,
                               input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {lo, hi};
      req_tuser  <= {v6, kind};
      do @(posedge clock); while (!req_tready);
      ledger.note_request(kind, v6, hi, lo);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [STRIKES_W-1:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      ledger.limit = value;
   endtask

   task automatic pick_peer(input int span, output bit v6, output logic [ADDR_W-1:0] hi,
                            output logic [ADDR_W-1:0] lo);
      int k;
      if ($urandom_range(0, 19) == 0) begin
         v6 = 1'($urandom_range(0, 1));
         hi = {$urandom, $urandom};
         lo = {$urandom, $urandom};
      end else begin
         k  = $urandom_range(0, span - 1);
         v6 = pool_v6[k];
         hi = pool_hi[k];
         lo = pool_lo[k];
         // ipv4 peers carry junk in the ignored bits
         if (!v6) begin
            lo[63:32] = $urandom;
            hi = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
         end
      end
   endtask

   task automatic random_phase(input int count, input int tick_per_mille, input int span);
      kind_type          kind;
      bit                v6;
      logic [ADDR_W-1:0] hi, lo;
      int                r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 999);
         if (r < tick_per_mille)
            kind = KIND_TICK;
         else if (r < tick_per_mille + 30)
            kind = KIND_NONE;
         else if ($urandom_range(0, 99) < 60)
            kind = KIND_STRIKE;
         else
            kind = KIND_QUERY;
         pick_peer(span, v6, hi, lo);
         send_request(kind, v6, hi, lo);
      end
   endtask

   initial begin
      logic [31:0] a;
      ledger      = new();
      gaps_on     = 1;
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_wr_en   = 0;
      csr_wr_data = '0;

      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_v6[i] = 1'($urandom_range(0, 1));
         pool_hi[i] = pool_v6[i] ? {$urandom, $urandom} : '0;
         pool_lo[i] = pool_v6[i] ? {$urandom, $urandom} : {32'h0, $urandom};
      end
      // same low bits in both families
      pool_v6[0] = 0;
      pool_hi[0] = '0;
      pool_v6[1] = 1;
      pool_hi[1] = '0;
      pool_lo[1] = {32'h0, pool_lo[0][31:0]};
      a = pool_lo[0][31:0];

      repeat (4) @(negedge clock);
      reset <= 0;

      send_request(KIND_QUERY, 0, '0, {32'h0, a});
      send_request(KIND_TICK, 0, '0, '0);
      send_request(KIND_NONE, 0, '0, {32'h0, a});
      send_request(KIND_STRIKE, 0, {$urandom, $urandom}, {$urandom, a});
      send_request(KIND_STRIKE, 0, '1, {32'hffff_ffff, a});
      send_request(KIND_STRIKE, 0, '0, {32'h0, a});
      send_request(KIND_QUERY, 0, {$urandom, $urandom}, {$urandom, a});
      send_request(KIND_STRIKE, 0, '0, {32'h0, a});
      send_request(KIND_QUERY, 0, '0, {32'h0, a});
      send_request(KIND_QUERY, 1, '0, {32'h0, a});
      send_request(KIND_STRIKE, 1, '0, {32'h0, a});
      send_request(KIND_STRIKE, 1, '1, '1);
      send_request(KIND_STRIKE, 0, '1, '1);
      send_request(KIND_QUERY, 0, '0, '0);
      send_request(KIND_STRIKE, 1, '0, '0);
      send_request(KIND_NONE, 1, '1, '1);
      send_request(KIND_TICK, 0, '0, '0);
      send_request(KIND_QUERY, 0, '0, {32'h0, a});
      send_request(KIND_TICK, 1, '1, '1);
      send_request(KIND_QUERY, 1, '1, '1);
      send_request(KIND_TICK, 0, '0, '0);
      send_request(KIND_QUERY, 0, '0, {32'h0, a});

      // zero limit: every strike appends, any present peer is blocked
      write_limit(4'd0);
      send_request(KIND_STRIKE, 0, '0, {32'h0, a});
      send_request(KIND_STRIKE, 0, '0, {32'h0, a});
      send_request(KIND_QUERY, 0, '0, {32'h0, a});
      send_request(KIND_QUERY, 1, '1, '1);

      write_limit(4'd1);
      random_phase(115, 20, 3);
      write_limit(4'd15);
      random_phase(60, 30, 3);
      drain_results();
      random_phase(55, 30, 3);
      write_limit(4'd0);
      random_phase(115, 100, 6);
      write_limit(STRIKES_W'($urandom_range(1, 15)));
      random_phase(115, 150, 12);
      write_limit(4'd2);
      random_phase(115, 300, 12);
      write_limit(STRIKES_W'($urandom_range(0, 15)));
      gaps_on = 0;
      random_phase(115, 80, 8);

      drain_results();
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.awaited.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
